// ===== src/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and codes for the page buffer pool replacement block.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int unsigned PageW = 24;

  typedef enum logic [2:0] {
    FUNC_PIN   = 3'd0,
    FUNC_UNPIN = 3'd1,
    FUNC_DIRTY = 3'd2,
    FUNC_FORCE = 3'd3,
    FUNC_FLUSH = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  localparam logic [1:0] CfgMode   = 2'd0;
  localparam logic [1:0] CfgFrames = 2'd1;

  typedef struct packed {
    logic [2:0]       func;
    logic [PageW-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       frame_index;
    logic             read_request;
    logic             write_request;
    logic [PageW-1:0] write_page;
    logic [31:0]      reads_done;
    logic [31:0]      writes_done;
    logic             last;
  } rsp_t;

endpackage

// ===== src/pbp_queue.sv =====
// ----------------------------------------------------------------------------
// pbp_queue
// Small register queue for requests or results.
// ----------------------------------------------------------------------------
module pbp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end
endmodule

// ===== src/pbp_engine.sv =====
// ----------------------------------------------------------------------------
// pbp_engine
// Frame table and sequencer: scans frames one per cycle for lookup, victim
// choice, LRU rebase and flush (flush only while the result queue is not full),
// then updates and emits results.
module pbp_engine import pbp_pkg::*; #(
  parameter int unsigned NumFrames = 16,
  parameter int unsigned StampBits = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mode_i,
  input  logic [4:0] frames_i,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       req_pop_o,
  output logic       rsp_push_o,
  output rsp_t       rsp_o,
  input  logic       rsp_full_i,
  output logic       busy_o
);
  localparam int unsigned FW = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam int unsigned CW = FW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_VICT, S_MIN, S_REB, S_LRU, S_FLUSH, S_EMIT
  } state_e;

  state_e state_q;
  logic [PageW-1:0]     page_q  [NumFrames];
  logic [15:0]          pins_q  [NumFrames];
  logic [StampBits-1:0] stamp_q [NumFrames];
  logic [NumFrames-1:0] valid_q, dirty_q;
  logic [StampBits-1:0] clock_q, best_st_q;
  logic [FW-1:0]        head_q, idx_q, pos_q, best_q;
  logic [CW-1:0]        cnt_q, n;
  logic                 found_q, flushed_q;
  logic [31:0]          rtot_q, wtot_q;
  req_t                 cur_q;
  rsp_t                 out_q;

  always_comb begin
    if (frames_i == '0) n = CW'(1);
    else if (32'(frames_i) > NumFrames) n = CW'(NumFrames);
    else n = CW'(frames_i);
  end

  assign busy_o     = (state_q != S_IDLE);
  assign req_pop_o  = (state_q == S_IDLE) && req_valid_i;
  assign rsp_push_o = (state_q == S_EMIT);
  assign rsp_o      = out_q;

  function automatic logic [FW-1:0] wrap(input logic [FW-1:0] p, input logic [CW-1:0] m);
    logic [CW-1:0] x;
    x = {1'b0, p} + 1'b1;
    wrap = (x >= m) ? '0 : x[FW-1:0];
  endfunction

  logic last_idx;
  assign last_idx = ({1'b0, idx_q} + 1'b1 >= n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0; dirty_q <= '0;
      clock_q <= '0; head_q <= '0;
      rtot_q <= '0; wtot_q <= '0;
      idx_q <= '0; pos_q <= '0; best_q <= '0; cnt_q <= '0;
      found_q <= 1'b0; flushed_q <= 1'b0; best_st_q <= '0;
      cur_q <= '0; out_q <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        page_q[i] <= '0; pins_q[i] <= '0; stamp_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: if (req_valid_i) begin
          cur_q   <= req_i;
          idx_q   <= '0;
          found_q <= 1'b0;
          flushed_q <= 1'b0;
          out_q   <= '0;
          if (req_i.func == FUNC_PIN) clock_q <= clock_q + 1'b1;
          if (req_i.func == FUNC_FLUSH) state_q <= S_FLUSH;
          else if (req_i.func inside {FUNC_PIN, FUNC_UNPIN, FUNC_DIRTY, FUNC_FORCE})
            state_q <= S_LOOK;
          else begin
            out_q.reads_done <= rtot_q; out_q.writes_done <= wtot_q;
            out_q.last <= 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_LOOK: begin
          if (valid_q[idx_q] && page_q[idx_q] == cur_q.page_number) begin
            out_q.frame_index <= 4'(idx_q);
            out_q.last <= 1'b1;
            out_q.reads_done <= rtot_q;
            out_q.writes_done <= wtot_q;
            case (cur_q.func)
              FUNC_PIN: begin
                if (pins_q[idx_q] != 16'hFFFF) pins_q[idx_q] <= pins_q[idx_q] + 1'b1;
                stamp_q[idx_q] <= clock_q;
              end
              FUNC_UNPIN: if (pins_q[idx_q] != '0) pins_q[idx_q] <= pins_q[idx_q] - 1'b1;
              FUNC_DIRTY: dirty_q[idx_q] <= 1'b1;
              default: begin
                dirty_q[idx_q] <= 1'b0;
                wtot_q <= wtot_q + 1'b1;
                out_q.writes_done <= wtot_q + 1'b1;
                out_q.write_request <= 1'b1;
                out_q.write_page <= page_q[idx_q];
              end
            endcase
            state_q <= S_EMIT;
          end else if (last_idx) begin
            idx_q <= '0;
            cnt_q <= '0;
            pos_q <= (head_q < n) ? head_q : '0;
            best_st_q <= stamp_q[0];
            if (cur_q.func != FUNC_PIN) begin
              out_q.status <= ST_MISSING;
              out_q.reads_done <= rtot_q; out_q.writes_done <= wtot_q;
              out_q.last <= 1'b1;
              state_q <= S_EMIT;
            end else state_q <= mode_i ? S_MIN : S_VICT;
          end else idx_q <= idx_q + 1'b1;
        end
        S_VICT: begin
          if (pins_q[pos_q] == '0) begin
            best_q <= pos_q; found_q <= 1'b1;
            head_q <= wrap(pos_q, n);
            state_q <= S_LRU;
          end else if (cnt_q + 1'b1 >= n) state_q <= S_LRU;
          else begin
            cnt_q <= cnt_q + 1'b1;
            pos_q <= wrap(pos_q, n);
          end
        end
        S_MIN: begin
          if (stamp_q[idx_q] < best_st_q) best_st_q <= stamp_q[idx_q];
          if (last_idx) begin idx_q <= '0; state_q <= S_REB; end
          else idx_q <= idx_q + 1'b1;
        end
        S_REB: begin
          stamp_q[idx_q] <= stamp_q[idx_q] - best_st_q;
          if (pins_q[idx_q] == '0 &&
              (!found_q || stamp_q[idx_q] - best_st_q < stamp_q[best_q])) begin
            best_q <= idx_q; found_q <= 1'b1;
          end
          if (idx_q == '0) clock_q <= clock_q - best_st_q;
          if (last_idx) state_q <= S_LRU;
          else idx_q <= idx_q + 1'b1;
        end
        S_LRU: begin
          out_q.last <= 1'b1;
          if (!found_q) begin
            out_q.status <= ST_NO_FREE;
            out_q.reads_done <= rtot_q; out_q.writes_done <= wtot_q;
          end else begin
            out_q.frame_index <= 4'(best_q);
            out_q.read_request <= 1'b1;
            out_q.reads_done <= rtot_q + 1'b1;
            rtot_q <= rtot_q + 1'b1;
            out_q.writes_done <= wtot_q;
            if (valid_q[best_q] && dirty_q[best_q]) begin
              out_q.write_request <= 1'b1;
              out_q.write_page <= page_q[best_q];
              out_q.writes_done <= wtot_q + 1'b1;
              wtot_q <= wtot_q + 1'b1;
            end
            dirty_q[best_q] <= 1'b0;
            valid_q[best_q] <= 1'b1;
            page_q[best_q]  <= cur_q.page_number;
            pins_q[best_q]  <= 16'd1;
            stamp_q[best_q] <= clock_q;
          end
          state_q <= S_EMIT;
        end
        S_FLUSH: if (!rsp_full_i) begin
          if (valid_q[idx_q] && dirty_q[idx_q]) begin
            logic [NumFrames-1:0] rest;
            rest = '0;
            for (int i = 0; i < NumFrames; i++)
              rest[i] = (i > idx_q) && (CW'(i) < n) && valid_q[i] && dirty_q[i];
            dirty_q[idx_q] <= 1'b0;
            wtot_q <= wtot_q + 1'b1;
            flushed_q <= 1'b1;
            out_q <= '{status: ST_OK, frame_index: 4'(idx_q), read_request: 1'b0,
                       write_request: 1'b1, write_page: page_q[idx_q],
                       reads_done: rtot_q, writes_done: wtot_q + 1'b1,
                       last: (rest == '0)};
            state_q <= S_EMIT;
          end else if (last_idx && !flushed_q) begin
            out_q <= '0;
            out_q.reads_done <= rtot_q; out_q.writes_done <= wtot_q;
            out_q.last <= 1'b1;
            state_q <= S_EMIT;
          end else if (!last_idx) idx_q <= idx_q + 1'b1;
        end
        S_EMIT: if (!rsp_full_i) begin
          if (cur_q.func == FUNC_FLUSH && !out_q.last) begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_FLUSH;
          end else state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/page_buffer_pool_replacement_top.sv =====
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement_top
// Page frame pool with FIFO or LRU victim choice.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// request  | push / full        | req_i  (func, page_number)
// result   | pop / empty        | rsp_o  (status ... last)
// config   | cfg_we_i           | cfg_idx_i, cfg_data_i
// A request waits in the request queue, is taken, then is looked up in up to
// n frames; on a pin miss it runs the FIFO scan or the LRU min and rebase
// passes plus an update, then is emitted into the result queue. Flush scans
// the frames and emits one result per write-back (one emit when nothing is
// dirty).
// Reset clears the frame table at once. Requests and results are queued so
// either side may stall independently; a full result queue holds the emit.
module page_buffer_pool_replacement_top import pbp_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  req_t       req_i,
  output logic       full,
  input  logic       pop,
  output rsp_t       rsp_o,
  output logic       empty,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);
  logic       mode_q;
  logic [4:0] frames_q;
  logic       rq_empty, rq_pop, rsp_push, rsp_full, busy;
  req_t       rq_data;
  rsp_t       eng_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; frames_q <= 5'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgMode) mode_q <= cfg_data_i[0];
      else if (cfg_idx_i == CfgFrames) frames_q <= cfg_data_i;
    end
  end

  pbp_queue #(.Width($bits(req_t)), .Depth(2)) u_rq (
    .clk_i, .rst_ni, .push_i(push), .data_i(req_i), .full_o(full),
    .pop_i(rq_pop), .data_o(rq_data), .empty_o(rq_empty));

  pbp_engine #(.NumFrames(NUM_FRAMES), .StampBits(STAMP_BITS)) u_eng (
    .clk_i, .rst_ni, .mode_i(mode_q), .frames_i(frames_q),
    .req_valid_i(!rq_empty), .req_i(rq_data), .req_pop_o(rq_pop),
    .rsp_push_o(rsp_push), .rsp_o(eng_rsp), .rsp_full_i(rsp_full), .busy_o(busy));

  pbp_queue #(.Width($bits(rsp_t)), .Depth(2)) u_sq (
    .clk_i, .rst_ni, .push_i(rsp_push), .data_i(eng_rsp), .full_o(rsp_full),
    .pop_i(pop), .data_o(rsp_o), .empty_o(empty));

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_pop |-> !busy) else $error("request taken while busy");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push && !rsp_full |=> !empty) else $error("result lost");
endmodule

// ===== tb/page_buffer_pool_replacement_top_tb.sv =====
// ----------------------------------------------------------------------------
// page_buffer_pool_replacement_top_tb
// Drives pin, unpin, mark-dirty, force, flush and unused function codes into
// the frame pool in both victim modes and at several pool sizes. A behavioral
// copy of the frame table predicts every result, and the results are checked
// in order. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
module page_buffer_pool_replacement_top_tb;
  import pbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  req_t       req_i = '0;
  logic       full;
  logic       pop = 1'b0;
  rsp_t       rsp_o;
  logic       empty;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [4:0] cfg_data_i = '0;

  page_buffer_pool_replacement_top DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // pool model
  logic        lru_mode;
  logic [4:0]  pool_size;
  logic [23:0] fr_page [NF];
  logic        fr_valid [NF];
  logic [15:0] fr_pins [NF];
  logic        fr_dirty [NF];
  logic [31:0] fr_stamp [NF];
  logic [31:0] access_clk;
  int          head;
  logic [31:0] rd_cnt, wr_cnt;

  rsp_t expected_rsp [$];
  int   errors = 0;
  logic [23:0] hot_pages [8];

  function automatic int active_n();
    if (pool_size == 0) return 1;
    if (pool_size > NF) return NF;
    return pool_size;
  endfunction

  function automatic void push_rsp(status_e st, int fi, logic rd, logic wr,
                                   logic [23:0] wp, logic lst);
    rsp_t r;
    r.status = st;
    r.frame_index = fi[3:0];
    r.read_request = rd;
    r.write_request = wr;
    r.write_page = wr ? wp : '0;
    r.reads_done = rd_cnt;
    r.writes_done = wr_cnt;
    r.last = lst;
    expected_rsp.push_back(r);
  endfunction

  function automatic int find_page(logic [23:0] pg, int n);
    for (int i = 0; i < n; i++) if (fr_valid[i] && fr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic int fifo_victim(int n);
    int pos;
    pos = (head < n) ? head : 0;
    for (int c = 0; c < n; c++) begin
      if (fr_pins[pos] == 0) begin
        head = (pos + 1 >= n) ? 0 : pos + 1;
        return pos;
      end
      pos = (pos + 1 >= n) ? 0 : pos + 1;
    end
    return -1;
  endfunction

  function automatic int lru_victim(int n);
    logic [31:0] oldest;
    int best;
    oldest = fr_stamp[0];
    best = -1;
    for (int i = 1; i < n; i++) if (fr_stamp[i] < oldest) oldest = fr_stamp[i];
    access_clk = access_clk - oldest;
    for (int i = 0; i < n; i++) fr_stamp[i] = fr_stamp[i] - oldest;
    for (int i = 0; i < n; i++) begin
      if (fr_pins[i] != 0) continue;
      if (best < 0 || fr_stamp[i] < fr_stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic void predict_request(req_t rq);
    int n, f, cnt, left;
    logic wr;
    logic [23:0] wp;
    n = active_n();
    case (rq.func)
      FUNC_PIN: begin
        access_clk = access_clk + 1;
        f = find_page(rq.page_number, n);
        if (f >= 0) begin
          if (fr_pins[f] != 16'hFFFF) fr_pins[f]++;
          fr_stamp[f] = access_clk;
          push_rsp(ST_OK, f, 0, 0, 0, 1);
        end else begin
          f = lru_mode ? lru_victim(n) : fifo_victim(n);
          if (f < 0) push_rsp(ST_NO_FREE, 0, 0, 0, 0, 1);
          else begin
            wr = fr_valid[f] && fr_dirty[f];
            wp = fr_page[f];
            if (wr) wr_cnt++;
            fr_dirty[f] = 0;
            fr_page[f] = rq.page_number;
            fr_valid[f] = 1;
            fr_pins[f] = 1;
            fr_stamp[f] = access_clk;
            rd_cnt++;
            push_rsp(ST_OK, f, 1, wr, wp, 1);
          end
        end
      end
      FUNC_UNPIN, FUNC_DIRTY, FUNC_FORCE: begin
        f = find_page(rq.page_number, n);
        if (f < 0) push_rsp(ST_MISSING, 0, 0, 0, 0, 1);
        else if (rq.func == FUNC_UNPIN) begin
          if (fr_pins[f] != 0) fr_pins[f]--;
          push_rsp(ST_OK, f, 0, 0, 0, 1);
        end else if (rq.func == FUNC_DIRTY) begin
          fr_dirty[f] = 1;
          push_rsp(ST_OK, f, 0, 0, 0, 1);
        end else begin
          fr_dirty[f] = 0;
          wr_cnt++;
          push_rsp(ST_OK, f, 0, 1, fr_page[f], 1);
        end
      end
      FUNC_FLUSH: begin
        cnt = 0;
        for (int i = 0; i < n; i++) if (fr_valid[i] && fr_dirty[i]) cnt++;
        if (cnt == 0) push_rsp(ST_OK, 0, 0, 0, 0, 1);
        left = cnt;
        for (int i = 0; i < n; i++) begin
          if (!(fr_valid[i] && fr_dirty[i])) continue;
          fr_dirty[i] = 0;
          wr_cnt++;
          left--;
          push_rsp(ST_OK, i, 0, 1, fr_page[i], left == 0);
        end
      end
      default: push_rsp(ST_OK, 0, 0, 0, 0, 1);
    endcase
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send_request(logic [2:0] fn, logic [23:0] pg);
    req_t rq;
    int gap;
    rq.func = fn;
    rq.page_number = pg;
    gap = short_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_request(rq);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_rsp.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMode) lru_mode = val[0];
    else if (idx == CfgFrames) pool_size = val;
    @(posedge clk_i);
  endtask

  // result checker
  initial begin
    rsp_t e;
    int stall;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected result %p", rsp_o);
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_o.status); errors++;
          end
          if (rsp_o.frame_index !== e.frame_index) begin
            $error("frame_index exp %0d got %0d", e.frame_index, rsp_o.frame_index);
            errors++;
          end
          if (rsp_o.read_request !== e.read_request) begin
            $error("read_request exp %0d got %0d", e.read_request, rsp_o.read_request);
            errors++;
          end
          if (rsp_o.write_request !== e.write_request) begin
            $error("write_request exp %0d got %0d", e.write_request,
                   rsp_o.write_request);
            errors++;
          end
          if (rsp_o.write_page !== e.write_page) begin
            $error("write_page exp %h got %h", e.write_page, rsp_o.write_page);
            errors++;
          end
          if (rsp_o.reads_done !== e.reads_done) begin
            $error("reads_done exp %0d got %0d", e.reads_done, rsp_o.reads_done);
            errors++;
          end
          if (rsp_o.writes_done !== e.writes_done) begin
            $error("writes_done exp %0d got %0d", e.writes_done, rsp_o.writes_done);
            errors++;
          end
          if (rsp_o.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, rsp_o.last); errors++;
          end
        end
      end
      stall = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  task automatic test_directed();
    send_request(FUNC_FLUSH, 24'h0);
    send_request(FUNC_UNPIN, 24'hFFFFFF);
    send_request(FUNC_PIN, 24'h000000);
    send_request(FUNC_PIN, 24'hFFFFFF);
    send_request(FUNC_PIN, 24'hFFFFFF);
    send_request(FUNC_DIRTY, 24'hFFFFFF);
    send_request(FUNC_DIRTY, 24'h000000);
    send_request(FUNC_FORCE, 24'h000000);
    send_request(FUNC_FORCE, 24'h000000);
    send_request(FUNC_FLUSH, 24'h123456);
    send_request(FUNC_UNPIN, 24'h000000);
    send_request(FUNC_UNPIN, 24'h000000);
    send_request(3'd5, 24'hAAAAAA);
    send_request(3'd6, 24'h555555);
    send_request(3'd7, 24'h0);
    wait_idle();
  endtask

  // tiny pool: fill, exhaust, dirty victim write-back
  task automatic test_small_pool(logic mode);
    write_cfg(CfgMode, {4'b0, mode});
    write_cfg(CfgFrames, 5'd0);
    send_request(FUNC_PIN, 24'h11);
    send_request(FUNC_PIN, 24'h22);
    send_request(FUNC_DIRTY, 24'h11);
    send_request(FUNC_UNPIN, 24'h11);
    send_request(FUNC_PIN, 24'h22);
    send_request(FUNC_UNPIN, 24'h22);
    wait_idle();
    write_cfg(CfgFrames, 5'd31);
    wait_idle();
  endtask

  task automatic test_random(logic mode, logic [4:0] size, int count);
    logic [2:0] fn;
    logic [23:0] pg;
    int r;
    write_cfg(CfgMode, {4'b0, mode});
    write_cfg(CfgFrames, size);
    for (int i = 0; i < 8; i++) hot_pages[i] = 24'($urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) fn = FUNC_PIN;
      else if (r < 65) fn = FUNC_UNPIN;
      else if (r < 80) fn = FUNC_DIRTY;
      else if (r < 88) fn = FUNC_FORCE;
      else if (r < 95) fn = FUNC_FLUSH;
      else fn = 3'($urandom_range(5, 7));
      pg = ($urandom_range(0, 9) < 8) ? hot_pages[$urandom_range(0, 7)]
                                       : 24'($urandom);
      send_request(fn, pg);
    end
    send_request(FUNC_FLUSH, 24'h0);
    wait_idle();
  endtask

  initial begin
    lru_mode = 0;
    pool_size = 16;
    for (int i = 0; i < NF; i++) begin
      fr_page[i] = 0; fr_valid[i] = 0; fr_pins[i] = 0;
      fr_dirty[i] = 0; fr_stamp[i] = 0;
    end
    access_clk = 0;
    head = 0;
    rd_cnt = 0;
    wr_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_small_pool(1'b0);
    test_small_pool(1'b1);
    test_random(1'b0, 5'd4, 20);
    test_random(1'b1, 5'd4, 20);
    test_random(1'b1, 5'd16, 20);
    test_random(1'b0, 5'd16, 20);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== page_buffer_pool_replacement_top.f =====
src/pbp_pkg.sv
src/pbp_queue.sv
src/pbp_engine.sv
src/page_buffer_pool_replacement_top.sv
tb/page_buffer_pool_replacement_top_tb.sv
